// File: rtl/fixed_frame_command_deframer_assert.svh
// assertion macros for the frame deframer
// expects clk and arst_n in the scope of each use
`ifndef FIXED_FRAME_COMMAND_DEFRAMER_ASSERT_SVH
`define FIXED_FRAME_COMMAND_DEFRAMER_ASSERT_SVH

`ifndef SYNTHESIS

// property checked while out of reset
`define FCD_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// property checked on every edge, reset included
`define FCD_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define FCD_ASSERT(label, prop, msg)
`define FCD_ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

// File: rtl/fcd_pkg.sv
// shared types, codes and constants of the frame deframer
// no dependencies
`timescale 1ns / 1ps

package fcd_pkg;

	localparam int DATA_BYTES    = 4;
	localparam int QUEUE_DEPTH   = 2;
	localparam int PAYLOAD_BYTES = 4;
	localparam int LANE_W        = $clog2(PAYLOAD_BYTES);

	localparam logic [7:0] HDR_BYTE   = 8'hAA;
	localparam logic [7:0] END_BYTE   = 8'h55;
	localparam logic [7:0] LED_DEV    = 8'h10;
	localparam logic [7:0] LED_ON_ACT = 8'h01;
	localparam logic [7:0] LOCK_DEV   = 8'hFF;
	localparam logic [7:0] LOCK_TYPE  = 8'h03;

	typedef logic [1:0] status_t;
	localparam status_t STATUS_OK      = 2'd0;
	localparam status_t STATUS_BAD_END = 2'd1;
	localparam status_t STATUS_BAD_SUM = 2'd2;

	// role of a byte inside the frame
	typedef logic [2:0] kind_t;
	localparam kind_t KIND_HDR   = 3'd0;
	localparam kind_t KIND_TYPE  = 3'd1;
	localparam kind_t KIND_DEV   = 3'd2;
	localparam kind_t KIND_ACT   = 3'd3;
	localparam kind_t KIND_DATA  = 3'd4;
	localparam kind_t KIND_CHECK = 3'd5;
	localparam kind_t KIND_END   = 3'd6;

	typedef struct packed {
		kind_t             kind;
		logic              keep;
		logic [LANE_W-1:0] lane;
		logic [7:0]        data;
	} item_t;

	typedef struct packed {
		status_t     status;
		logic [7:0]  pkt_type;
		logic [7:0]  device_id;
		logic [7:0]  action_code;
		logic [31:0] payload;
		logic        led_update;
		logic        led_on;
		logic        lock_request;
	} result_t;

endpackage

// File: rtl/fcd_if.sv
// valid/ready channel interfaces: received bytes in, decoded frames out
// no dependencies
`timescale 1ns / 1ps

interface fcd_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface fcd_res_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [7:0]  pkt_type;
	logic [7:0]  device_id;
	logic [7:0]  action_code;
	logic [31:0] payload;
	logic        led_update;
	logic        led_on;
	logic        lock_request;

	modport source (output valid, output status, output pkt_type, output device_id,
		output action_code, output payload, output led_update, output led_on,
		output lock_request, input ready);
	modport sink (input valid, input status, input pkt_type, input device_id,
		input action_code, input payload, input led_update, input led_on,
		input lock_request, output ready);
endinterface

// File: rtl/fixed_frame_command_deframer.sv
// top level of the fixed-length command frame deframer
// depends on fcd_pkg, fcd_if, fcd_front, fcd_fifo, fcd_back and the assert header
`timescale 1ns / 1ps
// usage
// - rx carries one received byte per transfer; res carries one decoded frame
// - a frame is header 0xAA, type, device, action, DATA_BYTES data bytes,
//   an xor checksum over all earlier bytes, and end byte 0x55
// - bytes outside a frame other than 0xAA are dropped; no resync inside a frame
// - status: ok, bad end byte (takes priority), or checksum mismatch; the
//   dispatch flags are set only on ok frames
// - throughput: one byte per cycle while the queue has room, set by the
//   classify step in the front end and the xor/field update in the back end
// - result path: the queue registers the end byte, and the output register
//   loads the result when the back end takes that byte from the queue
// - a stalled res side holds the result in the output register; bytes keep
//   flowing until the queue between front and back end (QUEUE_DEPTH entries)
//   fills, then rx.ready drops
// - reset clears frame position, queue pointers and the output valid;
//   the block is waiting for a header afterwards

`include "fixed_frame_command_deframer_assert.svh"

module fixed_frame_command_deframer #(
	parameter int DATA_BYTES  = fcd_pkg::DATA_BYTES,
	parameter int QUEUE_DEPTH = fcd_pkg::QUEUE_DEPTH
) (
	input  logic     clk,
	input  logic     arst_n,
	fcd_rx_if.sink   rx,
	fcd_res_if.source res
);

	// front end to queue
	logic             f_valid;
	fcd_pkg::item_t   f_item;
	logic             f_ready;
	logic             front_idle;

	// queue to back end
	logic             q_valid;
	fcd_pkg::item_t   q_item;
	logic             q_ready;

	// back end result
	logic             r_valid;
	fcd_pkg::result_t r_data;

	fcd_front #(
		.DATA_BYTES (DATA_BYTES)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.rx         (rx),
		.push_valid (f_valid),
		.push_item  (f_item),
		.push_ready (f_ready),
		.idle       (front_idle)
	);

	fcd_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_item  (f_item),
		.push_ready (f_ready),
		.pop_valid  (q_valid),
		.pop_item   (q_item),
		.pop_ready  (q_ready)
	);

	fcd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (q_valid),
		.pop_item  (q_item),
		.pop_ready (q_ready),
		.res_valid (r_valid),
		.res_data  (r_data),
		.res_ready (res.ready)
	);

	// drive the result channel from the output register
	assign res.valid        = r_valid;
	assign res.status       = r_data.status;
	assign res.pkt_type     = r_data.pkt_type;
	assign res.device_id    = r_data.device_id;
	assign res.action_code  = r_data.action_code;
	assign res.payload      = r_data.payload;
	assign res.led_update   = r_data.led_update;
	assign res.led_on       = r_data.led_on;
	assign res.lock_request = r_data.lock_request;

	// a header taken while idle must leave the queue non-empty next cycle
	`FCD_ASSERT(a_hdr_queued, (rx.valid && rx.ready && front_idle && (rx.rx_byte == fcd_pkg::HDR_BYTE)) |=> q_valid, "header transfer did not reach the queue")
	// dispatch flags only on frames that passed both checks
	`FCD_ASSERT(a_flags_ok, (r_valid && (r_data.led_update || r_data.lock_request)) |-> (r_data.status == fcd_pkg::STATUS_OK), "dispatch flag on a failed frame")
	// led_on never without led_update
	`FCD_ASSERT(a_led_on_upd, (r_valid && r_data.led_on) |-> r_data.led_update, "led_on without led_update")
	// status is one of the three defined codes
	`FCD_ASSERT(a_status_code, r_valid |-> ((r_data.status == fcd_pkg::STATUS_OK) || (r_data.status == fcd_pkg::STATUS_BAD_END) || (r_data.status == fcd_pkg::STATUS_BAD_SUM)), "undefined status code")
	// no result leaves while in reset
	`FCD_ASSERT_ALWAYS(a_reset_quiet, !arst_n |-> !res.valid, "result valid during reset")

endmodule

// File: rtl/fcd_front.sv
// front end: tracks frame position and tags each byte with its role
// depends on fcd_pkg and fcd_rx_if
`timescale 1ns / 1ps

module fcd_front #(
	parameter int DATA_BYTES = fcd_pkg::DATA_BYTES
) (
	input  logic          clk,
	input  logic          arst_n,
	fcd_rx_if.sink        rx,
	output logic          push_valid,
	output fcd_pkg::item_t push_item,
	input  logic          push_ready,
	output logic          idle
);

	localparam int POS_CHECK = 4 + DATA_BYTES;
	localparam int POS_END   = 5 + DATA_BYTES;
	localparam int PW        = $clog2(POS_END + 1);

	logic [PW-1:0] pos_q;
	logic [PW-1:0] data_idx;
	logic          accept;
	logic          is_hdr;

	assign idle     = (pos_q == '0);
	assign is_hdr   = (rx.rx_byte == fcd_pkg::HDR_BYTE);
	assign rx.ready = push_ready;
	assign accept   = rx.valid && rx.ready;
	// bytes other than a header are dropped while idle
	assign push_valid = rx.valid && (!idle || is_hdr);
	assign data_idx   = pos_q - PW'(4);

	always_comb begin
		push_item.data = rx.rx_byte;
		push_item.keep = 1'b0;
		push_item.lane = data_idx[fcd_pkg::LANE_W-1:0];
		if (idle) begin
			push_item.kind = fcd_pkg::KIND_HDR;
		end else if (pos_q == PW'(1)) begin
			push_item.kind = fcd_pkg::KIND_TYPE;
		end else if (pos_q == PW'(2)) begin
			push_item.kind = fcd_pkg::KIND_DEV;
		end else if (pos_q == PW'(3)) begin
			push_item.kind = fcd_pkg::KIND_ACT;
		end else if (pos_q < PW'(POS_CHECK)) begin
			push_item.kind = fcd_pkg::KIND_DATA;
			// only the leading data bytes land in the payload field
			push_item.keep = (data_idx < PW'(fcd_pkg::PAYLOAD_BYTES));
		end else if (pos_q == PW'(POS_CHECK)) begin
			push_item.kind = fcd_pkg::KIND_CHECK;
		end else begin
			push_item.kind = fcd_pkg::KIND_END;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (accept) begin
			if (idle) begin
				if (is_hdr) begin
					pos_q <= PW'(1);
				end
			end else if (pos_q == PW'(POS_END)) begin
				pos_q <= '0;
			end else begin
				pos_q <= pos_q + PW'(1);
			end
		end
	end

endmodule

// File: rtl/fcd_fifo.sv
// short queue of tagged bytes between front and back end
// depends on fcd_pkg
`timescale 1ns / 1ps

module fcd_fifo #(
	parameter int DEPTH = fcd_pkg::QUEUE_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	input  fcd_pkg::item_t push_item,
	output logic           push_ready,
	output logic           pop_valid,
	output fcd_pkg::item_t pop_item,
	input  logic           pop_ready
);

	// the user must keep depth a power of two, at least two; the block does not enforce it
	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	fcd_pkg::item_t mem_q [DEPTH];
	logic [AW-1:0]  wr_ptr_q;
	logic [AW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;
	logic           do_push;
	logic           do_pop;

	assign push_ready = (count_q != CW'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_item   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + AW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

// File: rtl/fcd_back.sv
// back end: collects frame fields, checksum, and builds the result
// depends on fcd_pkg
`timescale 1ns / 1ps

module fcd_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            pop_valid,
	input  fcd_pkg::item_t  pop_item,
	output logic            pop_ready,
	output logic            res_valid,
	output fcd_pkg::result_t res_data,
	input  logic            res_ready
);

	logic [7:0]       xor_q;
	logic [7:0]       type_q;
	logic [7:0]       dev_q;
	logic [7:0]       act_q;
	logic [31:0]      payload_q;
	logic [7:0]       check_q;
	logic             out_valid_q;
	fcd_pkg::result_t result_q;
	fcd_pkg::result_t res_next;
	logic             is_end;
	logic             slot_free;
	logic             take;
	logic             ok;

	assign is_end    = (pop_item.kind == fcd_pkg::KIND_END);
	assign slot_free = !out_valid_q || res_ready;
	// only the end byte needs the output slot
	assign pop_ready = !is_end || slot_free;
	assign take      = pop_valid && pop_ready;
	assign res_valid = out_valid_q;
	assign res_data  = result_q;

	always_comb begin
		if (pop_item.data != fcd_pkg::END_BYTE) begin
			res_next.status = fcd_pkg::STATUS_BAD_END;
		end else if (check_q != xor_q) begin
			res_next.status = fcd_pkg::STATUS_BAD_SUM;
		end else begin
			res_next.status = fcd_pkg::STATUS_OK;
		end
		ok                    = (res_next.status == fcd_pkg::STATUS_OK);
		res_next.pkt_type     = type_q;
		res_next.device_id    = dev_q;
		res_next.action_code  = act_q;
		res_next.payload      = payload_q;
		res_next.led_update   = ok && (dev_q == fcd_pkg::LED_DEV);
		res_next.led_on       = ok && (dev_q == fcd_pkg::LED_DEV)
			&& (act_q == fcd_pkg::LED_ON_ACT);
		res_next.lock_request = ok && (dev_q == fcd_pkg::LOCK_DEV)
			&& (type_q == fcd_pkg::LOCK_TYPE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xor_q     <= '0;
			type_q    <= '0;
			dev_q     <= '0;
			act_q     <= '0;
			payload_q <= '0;
			check_q   <= '0;
		end else if (take) begin
			unique case (pop_item.kind)
				fcd_pkg::KIND_HDR: begin
					xor_q     <= fcd_pkg::HDR_BYTE;
					payload_q <= '0;
				end
				fcd_pkg::KIND_TYPE: begin
					type_q <= pop_item.data;
					xor_q  <= xor_q ^ pop_item.data;
				end
				fcd_pkg::KIND_DEV: begin
					dev_q <= pop_item.data;
					xor_q <= xor_q ^ pop_item.data;
				end
				fcd_pkg::KIND_ACT: begin
					act_q <= pop_item.data;
					xor_q <= xor_q ^ pop_item.data;
				end
				fcd_pkg::KIND_DATA: begin
					if (pop_item.keep) begin
						payload_q[8*pop_item.lane +: 8] <= pop_item.data;
					end
					xor_q <= xor_q ^ pop_item.data;
				end
				fcd_pkg::KIND_CHECK: begin
					check_q <= pop_item.data;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take && is_end) begin
			out_valid_q <= 1'b1;
		end else if (res_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && is_end) begin
			result_q <= res_next;
		end
	end

endmodule
